@@ hdl/tclw_pkg.sv @@
package tclw_pkg;

   // sizes of the line ring and the notify slot ring
   localparam int MAX_LINES    = 1024;
   localparam int NOTIFY_SLOTS = 4;

   localparam int ROW_W  = $clog2(MAX_LINES);
   localparam int N_W    = ROW_W + 1;
   localparam int SLOT_W = $clog2(NOTIFY_SLOTS);

   // fixed field widths
   localparam int CHAR_W      = 8;
   localparam int COL_W       = 8;
   localparam int LINES_W     = 11;
   localparam int ROW_OUT_W   = 10;
   localparam int NOTIFY_W    = 2;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // reset values of the registers and the state
   localparam logic [COL_W-1:0]   WIDTH_RESET   = 8'd38;
   localparam logic [LINES_W-1:0] LINES_RESET   = 11'd862;
   localparam logic [CHAR_W-1:0]  OR_MASK_RESET = 8'd0;
   localparam int ROW_RESET_INT  = 862 - 1;
   localparam int SLOT_RESET_INT = ROW_RESET_INT % NOTIFY_SLOTS;
   localparam logic [ROW_W-1:0]  ROW_RESET  = ROW_W'(ROW_RESET_INT);
   localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(SLOT_RESET_INT);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NOTIFY_SLOTS - 1);

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_COLOUR_A = 8'h01;
   localparam logic [CHAR_W-1:0] CHAR_COLOUR_B = 8'h02;
   localparam logic [CHAR_W-1:0] CHAR_NL       = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
   localparam logic [CHAR_W-1:0] COLOUR_BIT    = 8'h80;

   typedef enum logic [1:0] {
      REG_LINE_WIDTH  = 2'd0,
      REG_TOTAL_LINES = 2'd1,
      REG_OR_MASK     = 2'd2,
      REG_UNUSED      = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [COL_W-1:0]   line_width;
      logic [LINES_W-1:0] total_lines;
      logic [CHAR_W-1:0]  or_mask;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  ring_row;
      logic [SLOT_W-1:0] slot_index;
      logic              return_pending;
      logic              colour_on;
   } state_type;

   typedef struct packed {
      logic                 line_started;
      logic [NOTIFY_W-1:0]  notify_slot;
      logic                 write_valid;
      logic [ROW_OUT_W-1:0] write_row;
      logic [COL_W-1:0]     write_column;
      logic [CHAR_W-1:0]    write_char;
   } result_type;

   function automatic logic [NOTIFY_W-1:0] to_notify(input logic [SLOT_W-1:0] slot);
      logic [15:0] wide;
      wide = 16'(slot);
      return wide[NOTIFY_W-1:0];
   endfunction

   function automatic logic [ROW_OUT_W-1:0] to_row_out(input logic [ROW_W-1:0] row);
      logic [15:0] wide;
      wide = 16'(row);
      return wide[ROW_OUT_W-1:0];
   endfunction

endpackage

@@ hdl/tclw_if.sv @@
interface tclw_req_if import tclw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              string_first;
   logic [COL_W-1:0]  word_ahead;

   modport source (output valid, char_in, string_first, word_ahead, input ready);
   modport sink   (input valid, char_in, string_first, word_ahead, output ready);
endinterface

interface tclw_rsp_if import tclw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 line_started;
   logic [NOTIFY_W-1:0]  notify_slot;
   logic                 write_valid;
   logic [ROW_OUT_W-1:0] write_row;
   logic [COL_W-1:0]     write_column;
   logic [CHAR_W-1:0]    write_char;

   modport source (output valid, line_started, notify_slot, write_valid, write_row,
                   write_column, write_char, input ready);
   modport sink   (input valid, line_started, notify_slot, write_valid, write_row,
                   write_column, write_char, output ready);
endinterface

@@ hdl/tclw_csr.sv @@
module tclw_csr import tclw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_LINE_WIDTH:  cfg_in.line_width  = pwdata[COL_W-1:0];
            REG_TOTAL_LINES: cfg_in.total_lines = pwdata[LINES_W-1:0];
            REG_OR_MASK:     cfg_in.or_mask     = pwdata[CHAR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LINE_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.line_width);
         REG_TOTAL_LINES: prdata = CSR_DATA_W'(cfg_ff.total_lines);
         REG_OR_MASK:     prdata = CSR_DATA_W'(cfg_ff.or_mask);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width  <= WIDTH_RESET;
         cfg_ff.total_lines <= LINES_RESET;
         cfg_ff.or_mask     <= OR_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/tclw_step.sv @@
module tclw_step import tclw_pkg::*; (
   input  cfg_type           cfg,
   input  state_type         state,
   input  logic [CHAR_W-1:0] char_in,
   input  logic              string_first,
   input  logic [COL_W-1:0]  word_ahead,
   output state_type         state_next,
   output result_type        result
);

   logic [COL_W-1:0]  w;
   logic [N_W-1:0]    n;
   logic [ROW_W-1:0]  n_last;
   logic [ROW_W-1:0]  row0, row1, row2;
   logic [SLOT_W-1:0] slot1, slot2;
   logic [COL_W-1:0]  col0, col1, word_sat;
   logic [COL_W:0]    col_sum, col_inc;
   logic [CHAR_W-1:0] c;
   logic              colour_code, colour, active, started;

   always_comb begin
      // effective width and ring size
      w = (cfg.line_width == '0) ? COL_W'(1) : cfg.line_width;
      if (cfg.total_lines == '0) begin
         n = N_W'(1);
      end else if (16'(cfg.total_lines) > 16'(MAX_LINES)) begin
         n = N_W'(MAX_LINES);
      end else begin
         n = N_W'(cfg.total_lines);
      end
      n_last = ROW_W'(n - N_W'(1));

      // stale position
      row0 = (N_W'(state.ring_row) >= n) ? n_last : state.ring_row;
      col0 = (state.column >= w) ? '0 : state.column;

      // colour code
      colour_code = string_first &&
                    (char_in == CHAR_COLOUR_A || char_in == CHAR_COLOUR_B);
      if (colour_code) begin
         colour = 1'b1;
      end else if (string_first) begin
         colour = 1'b0;
      end else begin
         colour = state.colour_on;
      end
      c      = colour_code ? CHAR_NUL : char_in;
      active = (c != CHAR_NUL);

      // word wrap
      word_sat = (word_ahead > w) ? w : word_ahead;
      col_sum  = {1'b0, col0} + {1'b0, word_sat};
      col1     = (word_sat != w && col_sum > {1'b0, w}) ? '0 : col0;

      // undo of a line advance after a carriage return
      if (state.return_pending) begin
         row1  = (row0 == '0) ? n_last : row0 - ROW_W'(1);
         slot1 = (state.slot_index == '0) ? SLOT_LAST : state.slot_index - SLOT_W'(1);
      end else begin
         row1  = row0;
         slot1 = state.slot_index;
      end

      // line advance
      started = (col1 == '0);
      if (started) begin
         row2  = (N_W'(row1) + N_W'(1) >= n) ? '0 : row1 + ROW_W'(1);
         slot2 = (slot1 == SLOT_LAST) ? '0 : slot1 + SLOT_W'(1);
      end else begin
         row2  = row1;
         slot2 = slot1;
      end

      col_inc = {1'b0, col1} + (COL_W+1)'(1);

      state_next            = state;
      state_next.colour_on  = colour;
      state_next.ring_row   = row0;
      state_next.column     = col0;
      result                = '0;
      result.notify_slot    = to_notify(state.slot_index);
      result.write_row      = to_row_out(row0);

      if (active) begin
         state_next.ring_row       = row2;
         state_next.slot_index     = slot2;
         state_next.return_pending = 1'b0;
         result.line_started       = started;
         result.notify_slot        = to_notify(slot2);
         result.write_row          = to_row_out(row2);
         if (c == CHAR_NL) begin
            state_next.column = '0;
         end else if (c == CHAR_CR) begin
            state_next.column         = '0;
            state_next.return_pending = 1'b1;
         end else begin
            result.write_valid  = 1'b1;
            result.write_column = col1;
            result.write_char   = c | (colour ? COLOUR_BIT : CHAR_NUL) | cfg.or_mask;
            state_next.column   = (col_inc >= {1'b0, w}) ? '0 : col_inc[COL_W-1:0];
         end
      end
   end

endmodule

@@ hdl/text_console_line_wrapper.sv @@
// a result item appears on rsp in the cycle after its input item is accepted
// throughput: one item per cycle while rsp keeps up; the per-character step is a single pass of
//   compare and increment logic between the position registers and the result register
// a new item is taken whenever the result register is empty or is being drained
// reset (synchronous, active high): registers back to width 38, 862 lines, mask 0;
//   column 0, row 861, slot 1, no pending carriage return, colour off, rsp empty
module text_console_line_wrapper import tclw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tclw_req_if.sink              req,
   tclw_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   state_type  state_ff, state_in;
   result_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   // configuration registers behind the apb port
   tclw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // the whole per-character update: wrap, row advance, carriage return undo, colour
   tclw_step u_step (
      .cfg          (cfg),
      .state        (state_ff),
      .char_in      (req.char_in),
      .string_first (req.string_first),
      .word_ahead   (req.word_ahead),
      .state_next   (state_in),
      .result       (result_in)
   );

   // the result register parts the two sides: an item goes in as long as the
   // previous result has left or leaves in this same cycle
   assign req.ready  = ~rsp_valid_ff | rsp.ready;
   assign req_accept = req.valid & req.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // position state moves on each accepted item only
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.column         <= '0;
         state_ff.ring_row       <= ROW_RESET;
         state_ff.slot_index     <= SLOT_RESET;
         state_ff.return_pending <= 1'b0;
         state_ff.colour_on      <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.line_started = result_ff.line_started;
   assign rsp.notify_slot  = result_ff.notify_slot;
   assign rsp.write_valid  = result_ff.write_valid;
   assign rsp.write_row    = result_ff.write_row;
   assign rsp.write_column = result_ff.write_column;
   assign rsp.write_char   = result_ff.write_char;

   // a result with no character carries zero column and character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.write_valid |->
         result_ff.write_column == '0 && result_ff.write_char == '0)
      else $error("idle result carries column or character");

   // a null character leaves no line advance and no write
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req.char_in == CHAR_NUL |=>
         rsp_valid_ff && !result_ff.line_started && !result_ff.write_valid)
      else $error("null character produced output");

   // a pending carriage return always sits at column zero
   assert property (@(posedge clock) disable iff (reset)
      state_ff.return_pending |-> state_ff.column == '0)
      else $error("carriage return pending away from column zero");

   // the column never reaches the widest possible line
   assert property (@(posedge clock) disable iff (reset)
      state_ff.column != {COL_W{1'b1}})
      else $error("column ran past the widest line");

endmodule

@@ sim/tb_text_console_line_wrapper.sv @@
`timescale 1ns / 100ps

module tb_text_console_line_wrapper;

   import tclw_pkg::*;

   // one character as offered on the request channel
   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              string_first;
      logic [COL_W-1:0]  word_ahead;
   } char_item_type;

   // word breaks fall on any character at or below space
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // clock, reset and the register port
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tclw_req_if req_if ();
   tclw_rsp_if rsp_if ();

   text_console_line_wrapper u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // characters waiting to be offered, and console writes still to come back
   char_item_type pending_chars[$];
   result_type    expected_writes[$];

   // our own copy of the console position and of the registers
   state_type pos;
   cfg_type   console_cfg;

   // bookkeeping
   int  mismatches     = 0;
   int  chars_taken    = 0;
   int  writes_checked = 0;
   int  csr_writes     = 0;

   // flow control between the stimulus, driver and receiver
   logic          req_fired     = 1'b0;  // the offered item went in at the last rising edge
   logic          quiet         = 1'b0;  // no idling on either side from here on
   logic          long_hold_cmd = 1'b0;  // ask the receiver for one long hold-off
   logic          long_hold_seen = 1'b0;
   int            long_hold_left = 0;
   int            send_gap       = 0;
   int            stall_left     = 0;
   char_item_type drive_item;
   char_item_type taken_item;
   result_type    got_write;
   result_type    want_write;

   // ------------------------------------------------------------------
   // console model
   // ------------------------------------------------------------------

   task automatic reset_console_model();
      console_cfg.line_width  = WIDTH_RESET;
      console_cfg.total_lines = LINES_RESET;
      console_cfg.or_mask     = OR_MASK_RESET;
      pos.column         = '0;
      pos.ring_row       = ROW_RESET;
      pos.slot_index     = SLOT_RESET;
      pos.return_pending = 1'b0;
      pos.colour_on      = 1'b0;
   endtask

   // place one character and work out the console write it causes
   function automatic result_type place_char(input char_item_type it);
      result_type  res;
      int unsigned w;
      int unsigned n;
      int unsigned word;
      int unsigned c;
      // a zero width behaves as one, the ring is clamped to 1..MAX_LINES
      w = (console_cfg.line_width == 0) ? 1 : console_cfg.line_width;
      if (console_cfg.total_lines == 0)              n = 1;
      else if (console_cfg.total_lines > MAX_LINES)  n = MAX_LINES;
      else                                           n = console_cfg.total_lines;
      c    = it.char_in;
      word = it.word_ahead;
      res  = '0;

      // a position left over from a larger setting snaps back into range
      if (pos.ring_row >= n) pos.ring_row = ROW_W'(n - 1);
      if (pos.column >= w)   pos.column   = '0;

      // colour code opening a string is consumed, any other opener clears colour
      if (it.string_first && (it.char_in == CHAR_COLOUR_A || it.char_in == CHAR_COLOUR_B)) begin
         pos.colour_on = 1'b1;
         c = 0;
      end else if (it.string_first) begin
         pos.colour_on = 1'b0;
      end

      // null characters and colour codes opening a string leave the position alone
      if (c != 0) begin
         // word wrap, unless the word is at least a full line anyway
         if (word > w) word = w;
         if (word != w && pos.column + word > w) pos.column = '0;

         // a carriage return takes back the next row advance
         if (pos.return_pending) begin
            pos.ring_row   = (pos.ring_row == 0) ? ROW_W'(n - 1) : pos.ring_row - 1'b1;
            pos.slot_index = (pos.slot_index == 0) ? SLOT_LAST : pos.slot_index - 1'b1;
            pos.return_pending = 1'b0;
         end

         // start of line: step the ring row and the notify slot
         if (pos.column == 0) begin
            pos.ring_row   = (pos.ring_row + 1 >= n) ? '0 : pos.ring_row + 1'b1;
            pos.slot_index = (pos.slot_index + 1 >= NOTIFY_SLOTS) ? '0 : pos.slot_index + 1'b1;
            res.line_started = 1'b1;
         end

         if (c == CHAR_NL) begin
            pos.column = '0;
         end else if (c == CHAR_CR) begin
            pos.column = '0;
            pos.return_pending = 1'b1;
         end else begin
            res.write_valid  = 1'b1;
            res.write_column = pos.column;
            res.write_char   = it.char_in | (pos.colour_on ? COLOUR_BIT : '0)
                               | console_cfg.or_mask;
            pos.column = (pos.column + 1 >= w) ? '0 : pos.column + 1'b1;
         end
      end

      res.notify_slot = NOTIFY_W'(pos.slot_index);
      res.write_row   = ROW_OUT_W'(pos.ring_row);
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------
   // request driver: changes on the falling edge, holds until taken
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (quiet) send_gap = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            drive_item = pending_chars.pop_front();
            req_if.valid        <= 1'b1;
            req_if.char_in      <= drive_item.char_in;
            req_if.string_first <= drive_item.string_first;
            req_if.word_ahead   <= drive_item.word_ahead;
            // now and then a burst of silence before the next item
            if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // result receiver: random stall bursts plus one long hold-off
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (long_hold_cmd && !long_hold_seen) begin
         long_hold_seen = 1'b1;
         long_hold_left = 250;
      end
      if (long_hold_left > 0) begin
         // long enough for the block to fill and push back on its input
         long_hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 16);
      end
   end

   // ------------------------------------------------------------------
   // rising edge: predict on every accepted character, check every write
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            taken_item.char_in      = req_if.char_in;
            taken_item.string_first = req_if.string_first;
            taken_item.word_ahead   = req_if.word_ahead;
            expected_writes.push_back(place_char(taken_item));
            chars_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got_write.line_started = rsp_if.line_started;
            got_write.notify_slot  = rsp_if.notify_slot;
            got_write.write_valid  = rsp_if.write_valid;
            got_write.write_row    = rsp_if.write_row;
            got_write.write_column = rsp_if.write_column;
            got_write.write_char   = rsp_if.write_char;
            if (expected_writes.size() == 0) begin
               $error("result item arrived with nothing expected");
               mismatches++;
            end else begin
               want_write = expected_writes.pop_front();
               check_field("line_started", 32'(want_write.line_started),
                           32'(got_write.line_started));
               check_field("notify_slot",  32'(want_write.notify_slot),
                           32'(got_write.notify_slot));
               check_field("write_valid",  32'(want_write.write_valid),
                           32'(got_write.write_valid));
               check_field("write_row",    32'(want_write.write_row),
                           32'(got_write.write_row));
               check_field("write_column", 32'(want_write.write_column),
                           32'(got_write.write_column));
               check_field("write_char",   32'(want_write.write_char),
                           32'(got_write.write_char));
               writes_checked++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // register access and stimulus helpers
   // ------------------------------------------------------------------

   // write one register, then read it back
   task automatic csr_write(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      // setup then access phase of the write
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_LINE_WIDTH:  console_cfg.line_width  = value[COL_W-1:0];
         REG_TOTAL_LINES: console_cfg.total_lines = value[LINES_W-1:0];
         REG_OR_MASK:     console_cfg.or_mask     = value[CHAR_W-1:0];
         default: ;
      endcase
      csr_writes++;
      // read back at the same address
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_LINE_WIDTH:  want = CSR_DATA_W'(console_cfg.line_width);
         REG_TOTAL_LINES: want = CSR_DATA_W'(console_cfg.total_lines);
         default:         want = CSR_DATA_W'(console_cfg.or_mask);
      endcase
      check_field(idx.name(), want, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // all three registers, with junk in the unused upper bits
   task automatic set_console(input logic [COL_W-1:0] width, input logic [LINES_W-1:0] lines,
                              input logic [CHAR_W-1:0] mask);
      csr_write(REG_LINE_WIDTH,  ($urandom() << COL_W)   | CSR_DATA_W'(width));
      csr_write(REG_TOTAL_LINES, ($urandom() << LINES_W) | CSR_DATA_W'(lines));
      csr_write(REG_OR_MASK,     ($urandom() << CHAR_W)  | CSR_DATA_W'(mask));
   endtask

   function automatic void push_char(input logic [CHAR_W-1:0] c, input logic first,
                                     input logic [COL_W-1:0] word);
      char_item_type it;
      it.char_in      = c;
      it.string_first = first;
      it.word_ahead   = word;
      pending_chars.push_back(it);
   endfunction

   // mostly real strings with an honest word length, some raw noise
   task automatic queue_text(input int count);
      logic [CHAR_W-1:0] text[$];
      logic [CHAR_W-1:0] c;
      int made;
      int len;
      int run;
      int w;
      int k;
      logic coloured;
      made = 0;
      w = (console_cfg.line_width == 0) ? 1 : int'(console_cfg.line_width);
      while (made < count) begin
         if ($urandom_range(0, 99) < 15) begin
            // noise: any value in every field
            push_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      COL_W'($urandom_range(0, 255)));
            made++;
         end else begin
            text.delete();
            coloured = ($urandom_range(0, 3) == 0);
            if (coloured) begin
               push_char($urandom_range(0, 1) ? CHAR_COLOUR_A : CHAR_COLOUR_B, 1'b1,
                         COL_W'($urandom_range(0, 255)));
               made++;
            end
            len = $urandom_range(1, 48);
            repeat (len) begin
               k = $urandom_range(0, 99);
               if (k < 68)      c = CHAR_W'($urandom_range(8'h21, 8'h7E));
               else if (k < 86) c = CHAR_SPACE;
               else if (k < 91) c = CHAR_NL;
               else if (k < 95) c = CHAR_CR;
               else             c = CHAR_W'($urandom_range(1, 255));
               text.push_back(c);
            end
            for (int i = 0; i < text.size(); i++) begin
               // length of the word from here, saturated at the width
               run = 0;
               for (int j = i; j < text.size() && text[j] > CHAR_SPACE; j++) run++;
               if (run > w) run = w;
               push_char(text[i], (i == 0) && !coloured, COL_W'(run));
               made++;
            end
         end
      end
   endtask

   // hold off until everything offered has come back
   task automatic wait_idle();
      int guard;
      guard = 0;
      while ((pending_chars.size() != 0 || req_if.valid || expected_writes.size() != 0)
             && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      // the block answers in the cycle after taking an item
      repeat (3) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_if.valid        = 1'b0;
      req_if.char_in      = '0;
      req_if.string_first = 1'b0;
      req_if.word_ahead   = '0;
      rsp_if.ready        = 1'b0;
      reset_console_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: colour codes, nulls, newline and carriage return at the reset setting
      push_char(CHAR_COLOUR_A, 1'b1, 8'd0);   // colour on, nothing stored
      push_char("H", 1'b0, 8'd5);              // first row advance wraps the ring
      push_char("i", 1'b0, 8'd4);
      push_char(8'hFF, 1'b0, 8'd255);          // top character, word saturated
      push_char(CHAR_SPACE, 1'b0, 8'd0);
      push_char("w", 1'b0, 8'd38);             // word exactly one line long
      push_char(CHAR_NL, 1'b0, 8'd0);
      push_char(CHAR_CR, 1'b0, 8'd0);          // advance, then take it back
      push_char("x", 1'b0, 8'd1);
      push_char(CHAR_COLOUR_B, 1'b1, 8'd0);
      push_char(CHAR_NUL, 1'b0, 8'd0);         // null is ignored
      push_char(CHAR_NUL, 1'b1, 8'd3);         // null opening a string clears colour
      push_char(CHAR_COLOUR_A, 1'b0, 8'd1);    // colour codes mid-string are stored
      push_char(CHAR_COLOUR_B, 1'b0, 8'd1);
      push_char("a", 1'b1, 8'd200);
      push_char("b", 1'b0, 8'd30);
      push_char("c", 1'b0, 8'd37);             // does not fit the rest of the line: wrap
      push_char("d", 1'b0, 8'd1);
      push_char(CHAR_CR, 1'b0, 8'd0);
      push_char(CHAR_CR, 1'b0, 8'd0);          // back-to-back returns
      push_char(CHAR_NL, 1'b1, 8'd0);
      push_char(CHAR_CR, 1'b0, 8'd0);
      push_char(CHAR_NL, 1'b0, 8'd0);
      push_char(8'h7F, 1'b0, 8'd0);
      push_char(8'h80, 1'b0, 8'd37);
      wait_idle();

      // widest line, ring beyond its maximum, every mask bit set
      set_console(8'd255, 11'd2047, 8'hFF);
      queue_text(80);
      wait_idle();

      // shrink under the current position: stale column and row
      set_console(8'd3, 11'd5, 8'h00);
      queue_text(60);
      wait_idle();

      // one column, one row
      set_console(8'd1, 11'd1, 8'h00);
      queue_text(50);
      wait_idle();

      // zero width and zero rows
      set_console(8'd0, 11'd0, 8'h55);
      queue_text(50);
      wait_idle();

      // random settings; the first also gets the long receiver hold-off
      repeat (3) begin
         set_console(COL_W'($urandom_range(2, 40)), LINES_W'($urandom_range(1, MAX_LINES)),
                     $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 255)) : CHAR_W'(0));
         long_hold_cmd = 1'b1;
         queue_text(60);
         wait_idle();
      end

      // last stretch at full rate on both sides
      quiet = 1'b1;
      set_console(COL_W'($urandom_range(4, 80)), LINES_W'(MAX_LINES), 8'h00);
      queue_text(60);
      wait_idle();

      if (expected_writes.size() != 0) begin
         $error("%0d console writes never arrived", expected_writes.size());
         mismatches++;
      end

      $display("run summary: %0d characters taken, %0d console writes checked, %0d register writes",
               chars_taken, writes_checked, csr_writes);
      $display("widths 0 to 255, ring sizes 0 to 2047, colour, wrap, return and stale positions");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
